@@ design/otgr_pkg.sv @@
// shared constants, types and the 5x7 font table for the oled text renderer
package otgr_pkg;

	localparam int COLUMNS     = 128;
	localparam int PAGES       = 8;
	localparam int GLYPH_WIDTH = 5;
	localparam int PAGE_W      = $clog2(PAGES);
	localparam int COL_W       = 8;
	localparam int GLYPH_BITS  = GLYPH_WIDTH * 8;
	localparam int GIDX_W      = 7;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int STEP_W      = 4;

	// request kinds
	localparam logic REQ_CHAR   = 1'b0;
	localparam logic REQ_CURSOR = 1'b1;

	// controller bytes
	localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
	localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
	localparam logic [7:0] SPACER_BYTE   = 8'h00;
	localparam logic [7:0] CHAR_NL       = 8'h0A;
	localparam logic [7:0] CHAR_FIRST    = 8'h20;
	localparam logic [7:0] CHAR_LAST     = 8'h7E;

	// byte positions within one request's output sequence
	localparam logic [STEP_W-1:0] STEP_CMD_COL    = 4'd0;
	localparam logic [STEP_W-1:0] STEP_COL        = 4'd1;
	localparam logic [STEP_W-1:0] STEP_COL_END    = 4'd2;
	localparam logic [STEP_W-1:0] STEP_CMD_PAGE   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_PAGE       = 4'd4;
	localparam logic [STEP_W-1:0] STEP_PAGE_END   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_GLYPH0     = 4'd6;
	localparam logic [STEP_W-1:0] STEP_GLYPH_LAST = 4'd10;
	localparam logic [STEP_W-1:0] STEP_SPACER     = 4'd11;

	typedef struct packed {
		logic                  cursor;
		logic                  glyph;
		logic [PAGE_W-1:0]     page;
		logic [COL_W-1:0]      column;
		logic [GLYPH_BITS-1:0] bitmap;
	} job_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	// glyph columns, leftmost column in the top byte
	function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [GIDX_W-1:0] idx);
		logic [GLYPH_BITS-1:0] g;
		case (idx)
			7'd0:  g = 40'h0000000000;
			7'd1:  g = 40'h00002f0000;
			7'd2:  g = 40'h0007000700;
			7'd3:  g = 40'h147f147f14;
			7'd4:  g = 40'h242a7f2a12;
			7'd5:  g = 40'h2313086462;
			7'd6:  g = 40'h3649552250;
			7'd7:  g = 40'h0005030000;
			7'd8:  g = 40'h001c224100;
			7'd9:  g = 40'h0041221c00;
			7'd10: g = 40'h14083E0814;
			7'd11: g = 40'h08083E0808;
			7'd12: g = 40'h0000A06000;
			7'd13: g = 40'h0808080808;
			7'd14: g = 40'h0060600000;
			7'd15: g = 40'h2010080402;
			7'd16: g = 40'h3E5149453E;
			7'd17: g = 40'h00427F4000;
			7'd18: g = 40'h4261514946;
			7'd19: g = 40'h2141454B31;
			7'd20: g = 40'h1814127F10;
			7'd21: g = 40'h2745454539;
			7'd22: g = 40'h3C4A494930;
			7'd23: g = 40'h0171090503;
			7'd24: g = 40'h3649494936;
			7'd25: g = 40'h064949291E;
			7'd26: g = 40'h0036360000;
			7'd27: g = 40'h0056360000;
			7'd28: g = 40'h0814224100;
			7'd29: g = 40'h1414141414;
			7'd30: g = 40'h0041221408;
			7'd31: g = 40'h0201510906;
			7'd32: g = 40'h324959513E;
			7'd33: g = 40'h7C1211127C;
			7'd34: g = 40'h7F49494936;
			7'd35: g = 40'h3E41414122;
			7'd36: g = 40'h7F4141221C;
			7'd37: g = 40'h7F49494941;
			7'd38: g = 40'h7F09090901;
			7'd39: g = 40'h3E4149497A;
			7'd40: g = 40'h7F0808087F;
			7'd41: g = 40'h00417F4100;
			7'd42: g = 40'h2040413F01;
			7'd43: g = 40'h7F08142241;
			7'd44: g = 40'h7F40404040;
			7'd45: g = 40'h7F020C027F;
			7'd46: g = 40'h7F0408107F;
			7'd47: g = 40'h3E4141413E;
			7'd48: g = 40'h7F09090906;
			7'd49: g = 40'h3E4151215E;
			7'd50: g = 40'h7F09192946;
			7'd51: g = 40'h4649494931;
			7'd52: g = 40'h01017F0101;
			7'd53: g = 40'h3F4040403F;
			7'd54: g = 40'h1F2040201F;
			7'd55: g = 40'h3F4038403F;
			7'd56: g = 40'h6314081463;
			7'd57: g = 40'h0708700807;
			7'd58: g = 40'h6151494543;
			7'd59: g = 40'h007F414100;
			7'd60: g = 40'h55AA55AA55;
			7'd61: g = 40'h0041417F00;
			7'd62: g = 40'h0402010204;
			7'd63: g = 40'h4040404040;
			7'd64: g = 40'h0003050000;
			7'd65: g = 40'h2054545478;
			7'd66: g = 40'h7F48444438;
			7'd67: g = 40'h3844444420;
			7'd68: g = 40'h384444487F;
			7'd69: g = 40'h3854545418;
			7'd70: g = 40'h087E090102;
			7'd71: g = 40'h18A4A4A47C;
			7'd72: g = 40'h7F08040478;
			7'd73: g = 40'h00447D4000;
			7'd74: g = 40'h4080847D00;
			7'd75: g = 40'h7F10284400;
			7'd76: g = 40'h00417F4000;
			7'd77: g = 40'h7C04180478;
			7'd78: g = 40'h7C08040478;
			7'd79: g = 40'h3844444438;
			7'd80: g = 40'hFC24242418;
			7'd81: g = 40'h18242418FC;
			7'd82: g = 40'h7C08040408;
			7'd83: g = 40'h4854545420;
			7'd84: g = 40'h043F444020;
			7'd85: g = 40'h3C4040207C;
			7'd86: g = 40'h1C2040201C;
			7'd87: g = 40'h3C4030403C;
			7'd88: g = 40'h4428102844;
			7'd89: g = 40'h1CA0A0A07C;
			7'd90: g = 40'h4464544C44;
			7'd91: g = 40'h00107C8200;
			7'd92: g = 40'h0000FF0000;
			7'd93: g = 40'h00827C1000;
			7'd94: g = 40'h0006090906;
			default: g = 40'h0000000000;
		endcase
		return g;
	endfunction

endpackage

@@ design/otgr_req_if.sv @@
// request channel: character or set-cursor requests
interface otgr_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] char_code;
	logic [7:0] new_page;
	logic [7:0] new_column;

	modport source (output valid, output req_type, output char_code, output new_page,
		output new_column, input ready);
	modport sink (input valid, input req_type, input char_code, input new_page,
		input new_column, output ready);
endinterface

@@ design/otgr_out_if.sv @@
// result channel: controller bytes tagged command or data
interface otgr_out_if;
	logic       valid;
	logic       ready;
	logic       is_command;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output is_command, output out_byte, output last,
		input ready);
	modport sink (input valid, input is_command, input out_byte, input last,
		output ready);
endinterface

@@ design/oled_text_glyph_renderer.sv @@
// top level of the page-addressed oled text renderer with built-in 5x7 font
//
// req channel: one request per handshake, either a character to print or a
// set-cursor request (page below 8, column below 128; others are dropped).
// res channel: the controller byte stream, one byte per handshake, each
// tagged command or display data, with last on the final byte of a request.
// A character gives 6 data bytes, or 12 bytes when a line advance (right
// edge) comes first; a newline or a set-cursor request gives 6 command bytes.
// When the sequencer is idle, an accepted request is written into the job
// queue and its first byte then goes through the output register.
// Requests follow one another back to back; the output port, one byte per
// cycle while res.ready is high, sets the rate.
// The front end updates the cursor at once and queues up to two jobs, so
// requests keep being accepted while the sequencer works on earlier ones.
// Reset clears the cursor to page 0, column 0 and empties the queue.
// When the receiver stalls the output byte holds; once the queue is full,
// req.ready drops until bytes drain.
module oled_text_glyph_renderer import otgr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	otgr_req_if.sink   req,
	otgr_out_if.source res
);

	q_stat_t q_stat;
	job_t    push_job;
	job_t    head;
	logic    push;
	logic    pop;

	otgr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	otgr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	otgr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.res    (res)
	);

	// queue occupancy never runs past its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCNT_W'(QDEPTH))
		else $error("job queue overflow");

	// a request that ends in data ends with the blank spacer column
	a_spacer_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.last && !res.is_command |-> res.out_byte == SPACER_BYTE)
		else $error("data sequence does not end with spacer");

	// bytes of one request come without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready && !res.last |=> res.valid)
		else $error("gap inside a request's byte sequence");

	// nothing is popped from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty job queue");

endmodule

@@ design/otgr_front.sv @@
// front end: accepts requests, tracks the cursor and builds byte-sequence jobs
module otgr_front import otgr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	otgr_req_if.sink   req,
	input  q_stat_t    q_stat,
	output logic       push,
	output job_t       push_job
);

	logic [PAGE_W-1:0] page_q;
	logic [COL_W-1:0]  column_q;
	logic [PAGE_W-1:0] page_nxt;
	logic [COL_W-1:0]  column_nxt;
	logic [COL_W:0]    col_end;
	logic [PAGE_W-1:0] page_inc;
	logic [GIDX_W-1:0] gidx;
	logic              accept;
	logic              newline;
	logic              wrap;
	logic              cursor_ok;

	assign req.ready = !q_stat.full;
	assign accept    = req.valid && req.ready;

	always_comb begin
		col_end   = {1'b0, column_q} + (COL_W+1)'(GLYPH_WIDTH);
		newline   = (req.char_code == CHAR_NL);
		wrap      = newline || (col_end >= (COL_W+1)'(COLUMNS));
		page_inc  = (page_q == PAGE_W'(PAGES - 1)) ? '0 : page_q + 1'b1;
		cursor_ok = (req.new_page < 8'(PAGES)) && ({1'b0, req.new_column} < 9'(COLUMNS));
		// anything outside the printable range draws as a space
		if (req.char_code inside {[CHAR_FIRST:CHAR_LAST]}) begin
			gidx = GIDX_W'(req.char_code - CHAR_FIRST);
		end else begin
			gidx = '0;
		end

		push_job.bitmap = font_glyph(gidx);
		if (req.req_type == REQ_CURSOR) begin
			push_job.cursor = 1'b1;
			push_job.glyph  = 1'b0;
			push_job.page   = req.new_page[PAGE_W-1:0];
			push_job.column = req.new_column;
			page_nxt        = req.new_page[PAGE_W-1:0];
			column_nxt      = req.new_column;
			push            = accept && cursor_ok;
		end else begin
			push_job.cursor = wrap;
			push_job.glyph  = !newline;
			push_job.page   = wrap ? page_inc : page_q;
			push_job.column = wrap ? '0 : column_q;
			page_nxt        = push_job.page;
			column_nxt      = newline ? '0 : push_job.column + COL_W'(GLYPH_WIDTH + 1);
			push            = accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q   <= '0;
			column_q <= '0;
		end else if (push) begin
			page_q   <= page_nxt;
			column_q <= column_nxt;
		end
	end

endmodule

@@ design/otgr_queue.sv @@
// two-entry job queue between the front end and the byte sequencer
module otgr_queue import otgr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_job,
	input  logic    pop,
	output job_t    head,
	output q_stat_t q_stat
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.count = count_q;
	assign q_stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/otgr_back.sv @@
// back end: steps through a job and drives one controller byte per cycle while res.ready is high
module otgr_back import otgr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  q_stat_t    q_stat,
	output logic       pop,
	otgr_out_if.source res
);

	logic [STEP_W-1:0] step_q;
	logic              started_q;
	logic              out_valid_q;
	logic              out_cmd_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;

	logic [STEP_W-1:0] cur_step;
	logic [STEP_W-1:0] last_step;
	logic [2:0]        col_idx;
	logic              is_last;
	logic              load;
	logic [7:0]        byte_nxt;

	assign res.valid      = out_valid_q;
	assign res.is_command = out_cmd_q;
	assign res.out_byte   = out_byte_q;
	assign res.last       = out_last_q;

	always_comb begin
		cur_step  = started_q ? step_q : (head.cursor ? STEP_CMD_COL : STEP_GLYPH0);
		last_step = head.glyph ? STEP_SPACER : STEP_PAGE_END;
		is_last   = (cur_step == last_step);
		load      = !q_stat.empty && (!out_valid_q || res.ready);
		pop       = load && is_last;
		col_idx   = 3'(cur_step - STEP_GLYPH0);
		case (cur_step) inside
			STEP_CMD_COL:  byte_nxt = CMD_COL_ADDR;
			STEP_COL:      byte_nxt = head.column;
			STEP_COL_END:  byte_nxt = 8'(COLUMNS - 1);
			STEP_CMD_PAGE: byte_nxt = CMD_PAGE_ADDR;
			STEP_PAGE:     byte_nxt = 8'(head.page);
			STEP_PAGE_END: byte_nxt = 8'(PAGES - 1);
			[STEP_GLYPH0:STEP_GLYPH_LAST]:
				byte_nxt = head.bitmap[(GLYPH_WIDTH - 1 - int'(col_idx)) * 8 +: 8];
			default:       byte_nxt = SPACER_BYTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
			step_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				started_q   <= !is_last;
				step_q      <= cur_step + 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_cmd_q  <= (cur_step < STEP_GLYPH0);
			out_byte_q <= byte_nxt;
			out_last_q <= is_last;
		end
	end

endmodule

@@ tb/tb_top.sv @@
// testbench for the oled text renderer: predicts the controller byte stream and checks it
`timescale 1ns / 1ps

module tb_top;
	import otgr_pkg::*;

	typedef struct packed {
		logic       is_command;
		logic [7:0] out_byte;
		logic       last;
	} ctrl_byte_t;

	// 5x7 font, codes 0x20..0x7e, leftmost column in the top byte
	localparam logic [39:0] FONT [0:94] = '{
		40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
		40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
		40'h14083e0814, 40'h08083e0808, 40'h0000a06000, 40'h0808080808, 40'h0060600000,
		40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
		40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
		40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
		40'h0041221408, 40'h0201510906, 40'h324959513e, 40'h7c1211127c, 40'h7f49494936,
		40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
		40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
		40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
		40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
		40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
		40'h55aa55aa55, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
		40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
		40'h087e090102, 40'h18a4a4a47c, 40'h7f08040478, 40'h00447d4000, 40'h4080847d00,
		40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
		40'hfc24242418, 40'h18242418fc, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
		40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h1ca0a0a07c,
		40'h4464544c44, 40'h00107c8200, 40'h0000ff0000, 40'h00827c1000, 40'h0006090906
	};

	class display_stream_board;
		int         page_now;
		logic [7:0] column_now;
		ctrl_byte_t expected_bytes[$];
		int         errors;

		function new();
			page_now   = 0;
			column_now = 8'd0;
			errors     = 0;
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void push_byte(logic cmd, logic [7:0] b);
			ctrl_byte_t e;
			e.is_command = cmd;
			e.out_byte   = b;
			e.last       = 1'b0;
			expected_bytes.push_back(e);
		endfunction

		function void push_cursor();
			push_byte(1'b1, CMD_COL_ADDR);
			push_byte(1'b1, column_now);
			push_byte(1'b1, 8'(COLUMNS - 1));
			push_byte(1'b1, CMD_PAGE_ADDR);
			push_byte(1'b1, 8'(page_now));
			push_byte(1'b1, 8'(PAGES - 1));
		endfunction

		// work out the bytes one accepted request produces
		function void predict_request(logic rtype, logic [7:0] code, logic [7:0] np,
				logic [7:0] nc);
			int         before_cnt;
			logic       newline;
			logic [39:0] bits;
			int         idx;
			before_cnt = expected_bytes.size();
			if (rtype == REQ_CURSOR) begin
				if (np < PAGES && nc < COLUMNS) begin
					page_now   = np;
					column_now = nc;
					push_cursor();
				end
			end else begin
				newline = (code == CHAR_NL);
				if (newline || int'(column_now) + GLYPH_WIDTH >= COLUMNS) begin
					page_now   = (page_now + 1) % PAGES;
					column_now = 8'd0;
					push_cursor();
				end
				if (!newline) begin
					// unprintable codes fall back to the space glyph
					idx  = (code >= CHAR_FIRST && code <= CHAR_LAST) ? int'(code - CHAR_FIRST) : 0;
					bits = FONT[idx];
					for (int i = 0; i < GLYPH_WIDTH; i++)
						push_byte(1'b0, bits[39 - 8 * i -: 8]);
					push_byte(1'b0, SPACER_BYTE);
					column_now = column_now + 8'(GLYPH_WIDTH + 1);
				end
			end
			if (expected_bytes.size() > before_cnt)
				expected_bytes[expected_bytes.size() - 1].last = 1'b1;
		endfunction

		task check_byte(logic cmd, logic [7:0] b, logic lst);
			ctrl_byte_t e;
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected byte cmd=%0b byte=%02h last=%0b", cmd, b, lst));
			end else begin
				e = expected_bytes.pop_front();
				if (cmd !== e.is_command)
					report($sformatf("is_command %0b, want %0b (byte %02h)", cmd, e.is_command,
						e.out_byte));
				if (b !== e.out_byte)
					report($sformatf("out_byte %02h, want %02h", b, e.out_byte));
				if (lst !== e.last)
					report($sformatf("last %0b, want %0b (byte %02h)", lst, e.last, e.out_byte));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   src_burst;
	bit   snk_burst;

	otgr_req_if req();
	otgr_out_if res();

	display_stream_board sb = new();

	oled_text_glyph_renderer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.res    (res.source)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		arst_n         <= 1'b0;
		req.valid      <= 1'b0;
		req.req_type   <= REQ_CHAR;
		req.char_code  <= 8'd0;
		req.new_page   <= 8'd0;
		req.new_column <= 8'd0;
		res.ready      <= 1'b0;
	end

	initial begin
		#10_000_000;
		$display("[oled_text_glyph_renderer] ERROR");
		$finish;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			sb.check_byte(res.is_command, res.out_byte, res.last);
	end

	// receiver: random stall before each byte, with stall-free stretches
	initial begin : receiver
		int gap;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0)
				snk_burst = !snk_burst;
			gap = snk_burst ? 0 : $urandom_range(0, 18);
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			@(posedge clk);
			while (!res.valid) @(posedge clk);
		end
	end

	task automatic send_request(logic rtype, logic [7:0] code, logic [7:0] np, logic [7:0] nc);
		int gap;
		gap = src_burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.req_type   <= rtype;
		req.char_code  <= code;
		req.new_page   <= np;
		req.new_column <= nc;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sb.predict_request(rtype, code, np, nc);
	endtask

	// hold off the sender until every expected byte is out
	task automatic wait_drained();
		req.valid <= 1'b0;
		while (sb.expected_bytes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_char(logic [7:0] code);
		send_request(REQ_CHAR, code, 8'($urandom), 8'($urandom));
	endtask

	task automatic send_cursor(logic [7:0] np, logic [7:0] nc);
		send_request(REQ_CURSOR, 8'($urandom), np, nc);
	endtask

	task automatic send_random();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 60)
			send_char(8'($urandom_range(CHAR_FIRST, CHAR_LAST)));
		else if (kind < 70)
			send_char(CHAR_NL);
		else if (kind < 78)
			send_char(8'($urandom));
		else if (kind < 86)
			send_cursor(8'($urandom_range(0, PAGES - 1)), 8'($urandom_range(0, COLUMNS - 1)));
		else if (kind < 93)
			// columns near the right edge
			send_cursor(8'($urandom_range(0, PAGES - 1)),
				8'($urandom_range(COLUMNS - 10, COLUMNS - 1)));
		else
			send_cursor(8'($urandom), 8'($urandom));
	endtask

	initial begin : stimulus
		int w;
		src_burst = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		send_char(CHAR_NL);
		send_char(CHAR_FIRST);
		send_char(CHAR_LAST);
		send_char(8'h41);
		send_char(8'h00);
		send_char(8'hff);
		send_char(8'h7f);
		send_char(8'h1f);
		send_cursor(8'd7, 8'd127);
		send_char(8'h5a);
		send_cursor(8'd8, 8'd0);
		send_cursor(8'd0, 8'd128);
		send_cursor(8'hff, 8'hff);
		send_char(8'h61);
		send_cursor(8'd3, 8'd122);
		send_char(8'h30);
		send_char(8'h31);
		send_cursor(8'd5, 8'd123);
		send_char(8'h7b);
		send_cursor(8'd0, 8'd0);
		send_char(8'h80);
		send_cursor(8'd7, 8'd0);
		send_char(CHAR_NL);
		wait_drained();

		// random part in phases; gap-free or gappy sending is chosen at random every ten requests
		for (int ph = 0; ph < 4; ph++) begin
			src_burst = (ph % 2 == 1);
			for (int n = 0; n < 17; n++) begin
				if (n % 10 == 0)
					src_burst = $urandom_range(0, 2) == 0;
				send_random();
			end
			wait_drained();
		end
		// a long run of printable text so the text wraps onto a new line at least once
		src_burst = 1'b1;
		for (int n = 0; n < 30; n++)
			send_char(8'($urandom_range(CHAR_FIRST, CHAR_LAST)));
		req.valid <= 1'b0;

		for (w = 0; w < 20000 && sb.expected_bytes.size() != 0; w++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.expected_bytes.size() != 0)
			sb.report($sformatf("%0d expected bytes never came", sb.expected_bytes.size()));
		if (sb.errors == 0)
			$display("[oled_text_glyph_renderer] OK");
		else
			$display("[oled_text_glyph_renderer] ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
design/otgr_pkg.sv
design/otgr_req_if.sv
design/otgr_out_if.sv
design/otgr_front.sv
design/otgr_queue.sv
design/otgr_back.sv
design/oled_text_glyph_renderer.sv
tb/tb_top.sv
